@@ sv/c2s_pkg.sv @@
// Shared types, constants and the CORDIC arctangent table for the
// Cartesian to spherical converter. No dependencies.
package c2s_pkg;

  // Internal scale: coordinates carry 31 magnitude bits, angles are 32-bit turns.
  localparam int ITERS = 32;
  localparam int DW    = 36;
  localparam int GW    = 34;
  localparam int RW    = 34;

  localparam logic [29:0]   INV_GAIN_Q30 = 30'h26DD3B6A;
  localparam logic [GW-1:0] HALF_TURN    = GW'(64'h8000_0000);
  localparam logic [GW-1:0] QUARTER_TURN = GW'(64'h4000_0000);

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [GW-1:0] ang_t;

  // Sideband that rides along with each request through the pipeline.
  typedef struct packed {
    data_t       z;
    logic [31:0] az;
    logic        zv;
    logic        xyz;
  } side_t;

  // Arctangent of 2^-i as a fraction of a full turn times 2^32.
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    begin
      unique case (i)
        0:  r = 32'h20000000;  1:  r = 32'h12E4051E;
        2:  r = 32'h09FB385B;  3:  r = 32'h051111D4;
        4:  r = 32'h028B0D43;  5:  r = 32'h0145D7E1;
        6:  r = 32'h00A2F61E;  7:  r = 32'h00517C55;
        8:  r = 32'h0028BE53;  9:  r = 32'h00145F2F;
        10: r = 32'h000A2F98;  11: r = 32'h000517CC;
        12: r = 32'h00028BE6;  13: r = 32'h000145F3;
        14: r = 32'h0000A2FA;  15: r = 32'h0000517D;
        16: r = 32'h000028BE;  17: r = 32'h0000145F;
        18: r = 32'h00000A30;  19: r = 32'h00000518;
        20: r = 32'h0000028C;  21: r = 32'h00000146;
        22: r = 32'h000000A3;  23: r = 32'h00000051;
        24: r = 32'h00000029;  25: r = 32'h00000014;
        26: r = 32'h0000000A;  27: r = 32'h00000005;
        28: r = 32'h00000003;  29: r = 32'h00000001;
        30: r = 32'h00000001;
        default: r = 32'h00000000;
      endcase
      return r;
    end
  endfunction

endpackage

@@ sv/cartesian_to_spherical.sv @@
// Throughput: one request per cycle while the output is not stalled.
// An input register, two unrolled 32-stage CORDIC chains, two gain
// multipliers, a setup and an output register all advance together.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous) clears all valid bits and sets with_radius to 1.
// Top level of the Cartesian to spherical converter; depends on c2s_pkg,
// c2s_cordic_stage and c2s_gain.
module cartesian_to_spherical
  import c2s_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic                   cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [COORD_WIDTH-1:0] x,
  input  logic [COORD_WIDTH-1:0] y,
  input  logic [COORD_WIDTH-1:0] z,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [ANGLE_WIDTH-1:0] polar_angle,
  output logic [ANGLE_WIDTH-1:0] azimuth,
  output logic [COORD_WIDTH-1:0] radius,
  output logic                   zero_vector
);

  localparam int UPSHIFT = 32 - COORD_WIDTH;
  localparam logic [RW:0] RRND = (UPSHIFT > 0) ? (RW+1)'(1) << (UPSHIFT - 1) : '0;
  localparam logic [RW:0] RMAX = ((RW+1)'(1) << COORD_WIDTH) - (RW+1)'(1);
  localparam logic [32:0] ARND = (ANGLE_WIDTH < 32) ? 33'(1) << (31 - ANGLE_WIDTH) : '0;

  logic  en;
  logic  with_radius;

  // Whole pipeline moves unless a finished result is held.
  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      with_radius <= 1'b1;
    end else if (cfg_wr_en) begin
      with_radius <= cfg_wr_data;
    end
  end

  // Input scaling and half-plane fold for the azimuth CORDIC.
  data_t xs, ys, zs;
  assign xs = $signed({{(DW-COORD_WIDTH){x[COORD_WIDTH-1]}}, x}) <<< UPSHIFT;
  assign ys = $signed({{(DW-COORD_WIDTH){y[COORD_WIDTH-1]}}, y}) <<< UPSHIFT;
  assign zs = $signed({{(DW-COORD_WIDTH){z[COORD_WIDTH-1]}}, z}) <<< UPSHIFT;

  logic  v1 [0:ITERS];
  data_t p1 [0:ITERS];
  data_t q1 [0:ITERS];
  ang_t  a1 [0:ITERS];
  side_t s1 [0:ITERS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1[0] <= 1'b0;
    end else if (en) begin
      v1[0] <= in_valid;
    end
    if (en) begin
      s1[0].z   <= zs;
      s1[0].az  <= '0;
      s1[0].xyz <= (xs == '0) && (ys == '0);
      s1[0].zv  <= (xs == '0) && (ys == '0) && (zs == '0);
      if (xs[DW-1]) begin
        p1[0] <= -xs;
        q1[0] <= -ys;
        a1[0] <= $signed(HALF_TURN);
      end else begin
        p1[0] <= xs;
        q1[0] <= ys;
        a1[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_az
    c2s_cordic_stage #(.ITER(i)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .valid_i(v1[i]), .p_i(p1[i]), .q_i(q1[i]), .ang_i(a1[i]), .side_i(s1[i]),
      .valid_o(v1[i+1]), .p_o(p1[i+1]), .q_o(q1[i+1]), .ang_o(a1[i+1]),
      .side_o(s1[i+1])
    );
  end

  // Planar length from the first chain.
  logic          gv1;
  logic [RW-1:0] rho;
  ang_t          ga1;
  side_t         gs1;

  c2s_gain u_gain_rho (
    .clk(clk), .rst(rst), .en(en),
    .valid_i(v1[ITERS]), .v_i(p1[ITERS]), .ang_i(a1[ITERS]), .side_i(s1[ITERS]),
    .valid_o(gv1), .mag_o(rho), .ang_o(ga1), .side_o(gs1)
  );

  // Set up the polar CORDIC from (z, rho); keep the azimuth alongside.
  logic  v2 [0:ITERS];
  data_t p2 [0:ITERS];
  data_t q2 [0:ITERS];
  ang_t  a2 [0:ITERS];
  side_t s2 [0:ITERS];
  data_t rho_s;

  assign rho_s = $signed({{(DW-RW){1'b0}}, rho});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2[0] <= 1'b0;
    end else if (en) begin
      v2[0] <= gv1;
    end
    if (en) begin
      s2[0].z   <= gs1.z;
      s2[0].az  <= gs1.xyz ? 32'h0 : ga1[31:0];
      s2[0].xyz <= gs1.xyz;
      s2[0].zv  <= gs1.zv;
      if (gs1.z[DW-1]) begin
        p2[0] <= rho_s;
        q2[0] <= -gs1.z;
        a2[0] <= $signed(QUARTER_TURN);
      end else begin
        p2[0] <= gs1.z;
        q2[0] <= rho_s;
        a2[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_pol
    c2s_cordic_stage #(.ITER(i)) u_stage (
      .clk(clk), .rst(rst), .en(en),
      .valid_i(v2[i]), .p_i(p2[i]), .q_i(q2[i]), .ang_i(a2[i]), .side_i(s2[i]),
      .valid_o(v2[i+1]), .p_o(p2[i+1]), .q_o(q2[i+1]), .ang_o(a2[i+1]),
      .side_o(s2[i+1])
    );
  end

  // Radius from the second chain.
  logic          gv2;
  logic [RW-1:0] rad;
  ang_t          ga2;
  side_t         gs2;

  c2s_gain u_gain_rad (
    .clk(clk), .rst(rst), .en(en),
    .valid_i(v2[ITERS]), .v_i(p2[ITERS]), .ang_i(a2[ITERS]), .side_i(s2[ITERS]),
    .valid_o(gv2), .mag_o(rad), .ang_o(ga2), .side_o(gs2)
  );

  // Clamp, round to output widths and saturate the radius.
  logic [31:0] pol_c;
  logic [32:0] pol_sum;
  logic [32:0] az_sum;
  logic [RW:0] rsum;
  logic [RW:0] rsh;

  always_comb begin
    if (ga2[GW-1]) begin
      pol_c = '0;
    end else if (ga2 > $signed(HALF_TURN)) begin
      pol_c = HALF_TURN[31:0];
    end else begin
      pol_c = ga2[31:0];
    end
    pol_sum = {1'b0, pol_c} + ARND;
    az_sum  = {1'b0, gs2.az} + ARND;
    rsum    = {1'b0, rad} + RRND;
    rsh     = rsum >> UPSHIFT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= gv2;
    end
    if (en) begin
      zero_vector <= gs2.zv;
      if (gs2.zv) begin
        polar_angle <= '0;
        azimuth     <= '0;
        radius      <= '0;
      end else begin
        polar_angle <= pol_sum[32-ANGLE_WIDTH +: ANGLE_WIDTH];
        azimuth     <= az_sum[32-ANGLE_WIDTH +: ANGLE_WIDTH];
        if (!with_radius) begin
          radius <= '0;
        end else if (rsh > RMAX) begin
          radius <= '1;
        end else begin
          radius <= rsh[COORD_WIDTH-1:0];
        end
      end
    end
  end

endmodule

@@ sv/c2s_cordic_stage.sv @@
// One registered vectoring CORDIC iteration with its valid bit.
// Depends on c2s_pkg.
module c2s_cordic_stage
  import c2s_pkg::*;
#(
  parameter int ITER = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  valid_i,
  input  data_t p_i,
  input  data_t q_i,
  input  ang_t  ang_i,
  input  side_t side_i,
  output logic  valid_o,
  output data_t p_o,
  output data_t q_o,
  output ang_t  ang_o,
  output side_t side_o
);

  localparam logic [31:0] ATAN = atan_turn(ITER);

  data_t ps;
  data_t qs;
  ang_t  step;

  // Shifts round toward minus infinity.
  assign ps   = p_i >>> ITER;
  assign qs   = q_i >>> ITER;
  assign step = $signed({{(GW-32){1'b0}}, ATAN});

  // Rotate toward q = 0 and accumulate the angle.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
    if (en) begin
      side_o <= side_i;
      if (!q_i[DW-1]) begin
        p_o   <= p_i + qs;
        q_o   <= q_i - ps;
        ang_o <= ang_i + step;
      end else begin
        p_o   <= p_i - qs;
        q_o   <= q_i + ps;
        ang_o <= ang_i - step;
      end
    end
  end

endmodule

@@ sv/c2s_gain.sv @@
// Registered CORDIC gain correction: clamps at zero and scales by 1/K in Q30.
// Depends on c2s_pkg.
module c2s_gain
  import c2s_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          valid_i,
  input  data_t         v_i,
  input  ang_t          ang_i,
  input  side_t         side_i,
  output logic          valid_o,
  output logic [RW-1:0] mag_o,
  output ang_t          ang_o,
  output side_t         side_o
);

  logic [DW-2:0]    u;
  logic [DW+28:0]   prod;

  // Negative or zero lengths count as zero.
  assign u    = (v_i > 0) ? v_i[DW-2:0] : '0;
  assign prod = u * INV_GAIN_Q30;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_o <= 1'b0;
    end else if (en) begin
      valid_o <= valid_i;
    end
    if (en) begin
      mag_o  <= prod[RW+29:30];
      ang_o  <= ang_i;
      side_o <= side_i;
    end
  end

endmodule

@@ sv/c2s_checker.sv @@
// Port-level checks for the Cartesian to spherical converter, bound to the
// top level. Depends on cartesian_to_spherical.
module c2s_checker #(
  parameter int COORD_WIDTH = 16,
  parameter int ANGLE_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_stall,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic [ANGLE_WIDTH-1:0] polar_angle,
  input logic [ANGLE_WIDTH-1:0] azimuth,
  input logic [COORD_WIDTH-1:0] radius,
  input logic                   zero_vector
);

  localparam logic [ANGLE_WIDTH:0] HALF = (ANGLE_WIDTH+1)'(1) << (ANGLE_WIDTH - 1);

  // A held result keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(polar_angle) && $stable(azimuth)
      && $stable(radius) && $stable(zero_vector))
    else $error("result changed while stalled");

  // The origin reports all zeros.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_vector |-> polar_angle == '0 && azimuth == '0 && radius == '0)
    else $error("zero vector with nonzero fields");

  // The polar angle never exceeds half a turn.
  a_polar: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, polar_angle} <= HALF)
    else $error("polar angle beyond pi");

  // Reset empties the pipeline and releases the input.
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind cartesian_to_spherical c2s_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_c2s_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .polar_angle(polar_angle), .azimuth(azimuth),
  .radius(radius), .zero_vector(zero_vector)
);

@@ tb/cartesian_to_spherical_tb.sv @@
// Testbench for the Cartesian to spherical converter: directed and random points
// checked against an integer CORDIC predictor. Depends on c2s_pkg and cartesian_to_spherical.
`timescale 1ns / 1ps
module cartesian_to_spherical_tb;
  import c2s_pkg::*;

  localparam int CW = 16;
  localparam int AW = 16;
  localparam int PIPE_DEPTH = 69;

  // One converted point as the block should report it.
  typedef struct {
    logic [AW-1:0] polar;
    logic [AW-1:0] azim;
    logic [CW-1:0] rad;
    logic          zv;
  } sph_t;

  localparam logic [31:0] ATAN_TBL [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  logic          clk;
  logic          rst;
  logic          cfg_wr_en;
  logic          cfg_wr_data;
  logic          in_valid;
  logic          in_stall;
  logic [CW-1:0] x;
  logic [CW-1:0] y;
  logic [CW-1:0] z;
  logic          out_valid;
  logic          out_stall;
  logic [AW-1:0] polar_angle;
  logic [AW-1:0] azimuth;
  logic [CW-1:0] radius;
  logic          zero_vector;

  sph_t pending_points[$];
  bit   radius_on;
  int   send_idle_pct;
  int   recv_idle_pct;
  int   hold_requests;
  int   hold_served;
  int   hold_left;
  int   error_count;
  int   points_sent;
  int   points_checked;

  cartesian_to_spherical #(.COORD_WIDTH(CW), .ANGLE_WIDTH(AW)) DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .x(x), .y(y), .z(z),
    .out_valid(out_valid), .out_stall(out_stall),
    .polar_angle(polar_angle), .azimuth(azimuth), .radius(radius),
    .zero_vector(zero_vector)
  );

  // Clock with an 8 ns period.
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // Vectoring CORDIC: drives q to zero and returns the accumulated angle.
  function automatic longint cordic_vector(inout longint p, inout longint q);
    longint ps, qs, ang;
    ang = 0;
    for (int i = 0; i < 32; i++) begin
      ps = p >>> i;
      qs = q >>> i;
      if (q >= 0) begin
        p = p + qs; q = q - ps; ang += longint'(ATAN_TBL[i]);
      end else begin
        p = p - qs; q = q + ps; ang -= longint'(ATAN_TBL[i]);
      end
    end
    return ang;
  endfunction

  // Removes the CORDIC gain, truncating; negative values count as zero.
  function automatic bit [63:0] remove_gain(longint v);
    bit [63:0] u;
    u = (v > 0) ? 64'(v) : 64'd0;
    return (u * 64'h26DD3B6A) >> 30;
  endfunction

  function automatic logic [AW-1:0] round_turn(bit [63:0] a);
    return AW'((a + (64'd1 << (31 - AW))) >> (32 - AW));
  endfunction

  // Expected spherical coordinates of one point.
  function automatic sph_t to_spherical(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                                        logic signed [CW-1:0] pz);
    sph_t r;
    longint sx, sy, sz, a, b, pol, base;
    bit [63:0] az, rho, rad;
    sx = longint'(px) <<< (32 - CW);
    sy = longint'(py) <<< (32 - CW);
    sz = longint'(pz) <<< (32 - CW);
    if (sx == 0 && sy == 0 && sz == 0) begin
      r.polar = '0; r.azim = '0; r.rad = '0; r.zv = 1'b1;
      return r;
    end
    // Azimuth and length in the X-Y plane.
    if (sx == 0 && sy == 0) begin
      az = 0;
      rho = 0;
    end else begin
      a = sx; b = sy; base = 0;
      if (a < 0) begin
        a = -a; b = -b; base = 64'h8000_0000;
      end
      base += cordic_vector(a, b);
      az = 64'(base) & 64'hFFFF_FFFF;
      rho = remove_gain(a);
    end
    // Polar angle and radius from z and the planar length.
    if (sz < 0) begin
      a = longint'(rho); b = -sz; pol = 64'h4000_0000;
    end else begin
      a = sz; b = longint'(rho); pol = 0;
    end
    pol += cordic_vector(a, b);
    if (pol < 0) pol = 0;
    if (pol > 64'h8000_0000) pol = 64'h8000_0000;
    rad = remove_gain(a);
    rad = (rad + (64'd1 << (32 - CW - 1))) >> (32 - CW);
    if (rad > (64'd1 << CW) - 1) rad = (64'd1 << CW) - 1;
    r.polar = round_turn(64'(pol));
    r.azim = round_turn(az);
    r.rad = radius_on ? CW'(rad) : '0;
    r.zv = 1'b0;
    return r;
  endfunction

  // Receiver: random stalls, or a long hold when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each accepted result with the oldest expected point.
  always @(posedge clk) begin
    sph_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        e = pending_points.pop_front();
        points_checked++;
        if (polar_angle !== e.polar) begin
          $error("polar_angle: expected %0d, got %0d", e.polar, polar_angle);
          error_count++;
        end
        if (azimuth !== e.azim) begin
          $error("azimuth: expected %0d, got %0d", e.azim, azimuth);
          error_count++;
        end
        if (radius !== e.rad) begin
          $error("radius: expected %0d, got %0d", e.rad, radius);
          error_count++;
        end
        if (zero_vector !== e.zv) begin
          $error("zero_vector: expected %0d, got %0d", e.zv, zero_vector);
          error_count++;
        end
      end
    end
  end

  // Offer one point and wait until the block takes it.
  task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
                            logic signed [CW-1:0] pz);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    x <= px;
    y <= py;
    z <= pz;
    do @(posedge clk); while (in_stall);
    pending_points.insert(pending_points.size(), to_spherical(px, py, pz));
    points_sent++;
  endtask

  // Lower valid and wait until every expected result has arrived.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  task automatic write_with_radius(bit value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radius_on = value;
  endtask

  // Random coordinate: full range, small values, zero, or extremes.
  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(9))
      0, 1: return CW'($urandom_range(8) - 4);
      2: return ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
      3: return '0;
      default: return CW'($urandom);
    endcase
  endfunction

  task automatic send_random(int count);
    for (int i = 0; i < count; i++)
      send_point(rand_coord(), rand_coord(), rand_coord());
  endtask

  // Origin, axes, extremes and octant corners.
  task automatic test_directed;
    send_point(0, 0, 0);
    send_point(0, 0, 1);
    send_point(0, 0, -1);
    send_point(0, 0, 16'sh7FFF);
    send_point(0, 0, 16'sh8000);
    send_point(1, 0, 0);
    send_point(-1, 0, 0);
    send_point(0, 1, 0);
    send_point(0, -1, 0);
    send_point(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_point(16'sh8000, 16'sh8000, 16'sh8000);
    send_point(16'sh8000, 0, 0);
    send_point(16'sh7FFF, -1, 0);
    send_point(16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_point(16'sh8000, 16'sh7FFF, 16'sh8000);
    send_point(-100, -1, 5);
    send_point(1000, -1000, 0);
    send_point(-3, 4, -5);
    send_point(16'sh5555, 16'shAAAA, 16'sh00FF);
    drain();
  endtask

  task automatic test_random_phases;
    send_idle_pct = 36; recv_idle_pct = 75;
    send_random(300);
    send_idle_pct = 75; recv_idle_pct = 36;
    send_random(300);
    send_idle_pct = 0; recv_idle_pct = 0;
    send_random(250);
    drain();
  endtask

  task automatic test_radius_disabled;
    write_with_radius(1'b0);
    send_idle_pct = 20; recv_idle_pct = 20;
    send_point(0, 0, 0);
    send_point(16'sh8000, 16'sh8000, 16'sh8000);
    send_point(0, 0, 16'sh7FFF);
    send_random(80);
    drain();
    write_with_radius(1'b1);
  endtask

  // Long receiver hold while the sender keeps offering, then a full drain.
  task automatic test_backpressure;
    send_idle_pct = 0; recv_idle_pct = 10;
    hold_requests++;
    send_random(150);
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    in_valid = 1'b0;
    x = '0;
    y = '0;
    z = '0;
    radius_on = 1'b1;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    hold_served = 0;
    error_count = 0;
    points_sent = 0;
    points_checked = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phases();
    test_radius_disabled();
    test_backpressure();
    $display("Converted %0d points, %0d results checked, with radius output on and off,",
             points_sent, points_checked);
    $display("under sender and receiver stalls and a long output hold.");
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
